[rtl/lsbpe_pkg.sv]
// ----------------------------------------------------------------------------
// lsbpe_pkg
// Shared codes and constants for the LSB pixel bit embed/extract block.
// ----------------------------------------------------------------------------
package lsbpe_pkg;

	// input item codes; the fourth code carries no meaning and is dropped
	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_FLUSH = 2'd2
	} action_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PIXEL    = 2'd0,
		KIND_BYTE     = 2'd1,
		KIND_LEFTOVER = 2'd2,
		KIND_STATUS   = 2'd3
	} kind_t;

	// register indexes on the config port
	localparam logic [0:0] REG_BITS_PER_CHANNEL = 1'b0;
	localparam logic [0:0] REG_EXTRACT_MODE     = 1'b1;

	localparam int CHUNK_BITS  = 31;
	localparam int MAX_RESULTS = 3;

	// clamp bits_per_channel to 1..8
	function automatic logic [3:0] eff_k(input logic [3:0] k);
		logic [3:0] r;
		if (k == 4'd0) begin
			r = 4'd1;
		end else if (k > 4'd8) begin
			r = 4'd8;
		end else begin
			r = k;
		end
		return r;
	endfunction

endpackage

[rtl/lsb_pixel_bit_embed_extract.sv]
// ----------------------------------------------------------------------------
// lsb_pixel_bit_embed_extract
// Hides a byte stream in the low bits of RGB pixels, or pulls it back out,
// through an MSB-first bit queue.
// ----------------------------------------------------------------------------
// Usage: set bits_per_channel (k, 1..8; 0 acts as 1, above 8 acts as 8) and
// extract_mode over the APB port while the block is idle. In embed mode,
// data-byte items fill the queue (each answered by one status result, with
// overflow set when the byte was dropped) and each pixel item takes 3*k
// bits, k into the low bits of red, green and blue in that order; a pixel
// that finds fewer than 3*k bits goes out unchanged with underflow set. In
// extract mode, each pixel pushes its low k bits per channel and up to three
// whole bytes leave as byte results (a single status result when none is
// ready); data-byte items are dropped without a result. A flush item drains
// the queue in chunks of up to 31 bits, oldest first. Timing: the input
// register takes a transfer in every cycle while the output side keeps
// moving; each item passes from the input register into the output
// register, and its first result can transfer at the next rising edge at
// the earliest. Results leave one per cycle from the output register while
// result_stall is low; an item that makes n results (n = 1..3) holds the
// output until all n have left, and the output port is what bounds
// sustained throughput. Items without a result retire from the input
// register without touching the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lsb_pixel_bit_embed_extract #(
	parameter int QUEUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [7:0]  pixel_blue,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_byte,
	output logic [30:0] leftover_value,
	output logic [4:0]  leftover_count,
	output logic        overflow,
	output logic        underflow,
	output logic        last
);
	import lsbpe_pkg::*;

	localparam int CW       = $clog2(QUEUE_BITS + 1);
	localparam int EXT_BITS = MAX_RESULTS * CHUNK_BITS;

	// ---------------------------------------------------------------- config
	logic [3:0] bpc_q;
	logic       mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q  <= 4'd1;
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2:2])
				REG_BITS_PER_CHANNEL: bpc_q  <= pwdata[3:0];
				REG_EXTRACT_MODE:     mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			REG_BITS_PER_CHANNEL: prdata = {28'd0, bpc_q};
			REG_EXTRACT_MODE:     prdata = {31'd0, mode_q};
			default:              prdata = '0;
		endcase
	end

	// ------------------------------------------------------- input register
	logic       valid_s1;
	action_t    act_s1;
	logic [7:0] byte_s1;
	logic [7:0] red_s1, green_s1, blue_s1;

	// ------------------------------------------------------------ bit queue
	// Queue is kept MSB-aligned: the oldest bit sits at the top, and every
	// bit below the fill count is zero.
	logic [QUEUE_BITS-1:0] queue_q;
	logic [CW-1:0]         cnt_q;

	// ------------------------------------------------------ output register
	logic        valid_s2;
	logic [1:0]  n_s2;
	logic [1:0]  idx_q;
	logic [1:0]  kind_s2;
	logic [7:0]  red_s2, green_s2, blue_s2;
	logic [7:0]  byte_s2 [MAX_RESULTS];
	logic [30:0] lv_s2 [MAX_RESULTS];
	logic [4:0]  lc_s2 [MAX_RESULTS];
	logic        ov_s2, un_s2;

	logic res_xfer, s2_free, adv_s1;

	assign res_xfer = valid_s2 && !result_stall;
	assign last     = (idx_q == n_s2 - 2'd1);
	assign s2_free  = !valid_s2 || (res_xfer && last);

	// ------------------------------------------------------------ datapath
	logic [3:0]  kk;
	logic [4:0]  k3;
	logic [7:0]  cmask;
	logic [7:0]  lsh;
	logic [23:0] head, head_k, head_2k;
	logic [23:0] pw, push_wl;
	logic [4:0]  push_n;
	logic [QUEUE_BITS+23:0] ins_wide;
	logic [QUEUE_BITS-1:0]  q_push, q_x;
	logic [CW-1:0]          c_push, c_x;
	logic                   fits;
	logic [1:0]             nb;
	logic [EXT_BITS-1:0]    ext;
	logic [4:0]             c0, c1, c2;
	logic [CW-1:0]          rem1, rem2;

	logic [1:0]  nres_d;
	logic [1:0]  kind_d;
	logic [7:0]  red_d, green_d, blue_d;
	logic [7:0]  byte_d [MAX_RESULTS];
	logic [30:0] lv_d [MAX_RESULTS];
	logic [4:0]  lc_d [MAX_RESULTS];
	logic        ov_d, un_d;
	logic [QUEUE_BITS-1:0] q_d;
	logic [CW-1:0]         c_d;

	always_comb begin
		kk    = eff_k(bpc_q);
		k3    = {1'b0, kk} + {kk, 1'b0};
		cmask = 8'hFF >> (4'd8 - kk);
		lsh   = 8'd8 - {4'd0, kk};

		// head of queue split into the three k-bit fields
		head    = queue_q[QUEUE_BITS-1 -: 24];
		head_k  = head << kk;
		head_2k = head << {kk, 1'b0};

		// one insert shifter serves both byte push and pixel push
		pw = ({16'd0, red_s1 & cmask} << {kk, 1'b0})
			| ({16'd0, green_s1 & cmask} << kk)
			| {16'd0, blue_s1 & cmask};
		if (mode_q) begin
			push_wl = pw << (5'd24 - k3);
			push_n  = k3;
		end else begin
			push_wl = {byte_s1, 16'd0};
			push_n  = 5'd8;
		end
		fits     = ({1'b0, cnt_q} + (CW + 1)'(push_n)) <= (CW + 1)'(QUEUE_BITS);
		ins_wide = {push_wl, {QUEUE_BITS{1'b0}}} >> cnt_q;
		q_push   = queue_q | ins_wide[QUEUE_BITS+23:24];
		c_push   = cnt_q + CW'(push_n);
		q_x      = fits ? q_push : queue_q;
		c_x      = fits ? c_push : cnt_q;

		// whole bytes ready after an extract push
		if (c_x >= CW'(24)) begin
			nb = 2'd3;
		end else if (c_x >= CW'(16)) begin
			nb = 2'd2;
		end else if (c_x >= CW'(8)) begin
			nb = 2'd1;
		end else begin
			nb = 2'd0;
		end

		// flush chunks
		ext  = {queue_q, {(EXT_BITS - QUEUE_BITS){1'b0}}};
		c0   = (cnt_q > CW'(CHUNK_BITS)) ? 5'd31 : cnt_q[4:0];
		rem1 = cnt_q - CW'(c0);
		c1   = (rem1 > CW'(CHUNK_BITS)) ? 5'd31 : rem1[4:0];
		rem2 = rem1 - CW'(c1);
		c2   = (rem2 > CW'(CHUNK_BITS)) ? 5'd31 : rem2[4:0];

		nres_d  = 2'd0;
		kind_d  = KIND_STATUS;
		red_d   = '0;
		green_d = '0;
		blue_d  = '0;
		ov_d    = 1'b0;
		un_d    = 1'b0;
		q_d     = queue_q;
		c_d     = cnt_q;
		for (int j = 0; j < MAX_RESULTS; j++) begin
			byte_d[j] = '0;
			lv_d[j]   = '0;
			lc_d[j]   = '0;
		end

		unique case (act_s1)
			ACT_BYTE: begin
				if (!mode_q) begin
					nres_d = 2'd1;
					kind_d = KIND_STATUS;
					ov_d   = !fits;
					q_d    = q_x;
					c_d    = c_x;
				end
			end
			ACT_PIXEL: begin
				nres_d = 2'd1;
				if (!mode_q) begin
					kind_d = KIND_PIXEL;
					if (cnt_q < CW'(k3)) begin
						red_d   = red_s1;
						green_d = green_s1;
						blue_d  = blue_s1;
						un_d    = 1'b1;
					end else begin
						red_d   = (red_s1 & ~cmask) | (head[23:16] >> lsh);
						green_d = (green_s1 & ~cmask) | (head_k[23:16] >> lsh);
						blue_d  = (blue_s1 & ~cmask) | (head_2k[23:16] >> lsh);
						q_d     = queue_q << k3;
						c_d     = cnt_q - CW'(k3);
					end
				end else begin
					ov_d = !fits;
					if (nb == 2'd0) begin
						kind_d = KIND_STATUS;
					end else begin
						kind_d = KIND_BYTE;
						nres_d = nb;
					end
					byte_d[0] = q_x[QUEUE_BITS-1 -: 8];
					byte_d[1] = (nb > 2'd1) ? q_x[QUEUE_BITS-9 -: 8] : 8'd0;
					byte_d[2] = (nb > 2'd2) ? q_x[QUEUE_BITS-17 -: 8] : 8'd0;
					if (nb == 2'd0) begin
						byte_d[0] = 8'd0;
					end
					q_d = q_x << {nb, 3'b000};
					c_d = c_x - CW'({nb, 3'b000});
				end
			end
			ACT_FLUSH: begin
				kind_d = KIND_LEFTOVER;
				if (c2 != 5'd0) begin
					nres_d = 2'd3;
				end else if (c1 != 5'd0) begin
					nres_d = 2'd2;
				end else begin
					nres_d = 2'd1;
				end
				lv_d[0] = ext[EXT_BITS-1 -: CHUNK_BITS] >> (5'd31 - c0);
				lv_d[1] = ext[EXT_BITS-1-CHUNK_BITS -: CHUNK_BITS] >> (5'd31 - c1);
				lv_d[2] = ext[EXT_BITS-1-2*CHUNK_BITS -: CHUNK_BITS] >> (5'd31 - c2);
				lc_d[0] = c0;
				lc_d[1] = c1;
				lc_d[2] = c2;
				q_d     = '0;
				c_d     = '0;
			end
			default: ;
		endcase
	end

	// an item with no result retires at once; others wait for a free
	// output register
	assign adv_s1     = valid_s1 && ((nres_d == 2'd0) || s2_free);
	assign item_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			act_s1   <= action_t'(action);
			byte_s1  <= data_byte;
			red_s1   <= pixel_red;
			green_s1 <= pixel_green;
			blue_s1  <= pixel_blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_q <= '0;
			cnt_q   <= '0;
		end else if (adv_s1) begin
			queue_q <= q_d;
			cnt_q   <= c_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
			n_s2     <= 2'd1;
		end else if (adv_s1 && (nres_d != 2'd0)) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
			n_s2     <= nres_d;
		end else if (res_xfer) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (nres_d != 2'd0)) begin
			kind_s2  <= kind_d;
			red_s2   <= red_d;
			green_s2 <= green_d;
			blue_s2  <= blue_d;
			ov_s2    <= ov_d;
			un_s2    <= un_d;
			for (int j = 0; j < MAX_RESULTS; j++) begin
				byte_s2[j] <= byte_d[j];
				lv_s2[j]   <= lv_d[j];
				lc_s2[j]   <= lc_d[j];
			end
		end
	end

	assign result_valid   = valid_s2;
	assign kind           = kind_s2;
	assign out_red        = red_s2;
	assign out_green      = green_s2;
	assign out_blue       = blue_s2;
	assign out_byte       = byte_s2[idx_q];
	assign leftover_value = lv_s2[idx_q];
	assign leftover_count = lc_s2[idx_q];
	assign overflow       = ov_s2;
	assign underflow      = un_s2;

	// ------------------------------------------------------------ checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_BITS))
		else $error("queue fill count above capacity");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < n_s2))
		else $error("result index past result count");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && act_s1 == ACT_FLUSH) |=> (cnt_q == '0))
		else $error("queue not empty after flush");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule
